// ----- src/spr_pkg.sv -----
// Shared constants for the stepper period ramp block.
`timescale 1ns / 1ps

package spr_pkg;

   localparam int SPR_PERIOD_BITS = 20;

   localparam logic [31:0] RESET_MIN_PERIOD = 32'd156;
   localparam logic [31:0] RESET_MAX_PERIOD = 32'd1000000;
   localparam logic [31:0] RESET_ACCEL_STEP = 32'd10000;

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCEL_STEP = 2'd2;

endpackage

// ----- src/spr_req_if.sv -----
// Input channel carrying the sampled button level for one tick.
`timescale 1ns / 1ps

interface spr_req_if;
   logic valid;
   logic ready;
   logic button_level;

   modport source (output valid, output button_level, input ready);
   modport sink (input valid, input button_level, output ready);
endinterface

// ----- src/spr_rsp_if.sv -----
// Result channel carrying the PWM settings and the direction level for one tick.
`timescale 1ns / 1ps

interface spr_rsp_if #(
   parameter int PERIOD_BITS = spr_pkg::SPR_PERIOD_BITS
);
   logic                   valid;
   logic                   ready;
   logic [PERIOD_BITS-1:0] pwm_period;
   logic [PERIOD_BITS-2:0] pwm_pulse;
   logic                   motor_direction;

   modport source (output valid, output pwm_period, output pwm_pulse,
                   output motor_direction, input ready);
   modport sink (input valid, input pwm_period, input pwm_pulse,
                 input motor_direction, output ready);
endinterface

// ----- src/stepper_period_ramp.sv -----
// Stepper step-period ramp generator with button-controlled ramp reversal.
// The result of a tick is registered and appears on the result channel in the cycle after its transfer.
// Throughput: one tick per cycle; the single output register takes a new result
// whenever it is empty or its current result is transferred in the same cycle.
// Reset is synchronous and active high; it loads the default limits and step, sets the
// period to the maximum, and clears the ramp direction, motor direction and button history.
`timescale 1ns / 1ps

module stepper_period_ramp #(
   parameter int PERIOD_BITS = spr_pkg::SPR_PERIOD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   spr_req_if.sink                           req_chan,
   spr_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_en,
   input  logic [spr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [PERIOD_BITS-1:0]            csr_wdata
);

   logic [PERIOD_BITS-1:0] min_period_ff, min_period_in;
   logic [PERIOD_BITS-1:0] max_period_ff, max_period_in;
   logic [PERIOD_BITS-1:0] accel_step_ff, accel_step_in;

   logic [PERIOD_BITS-1:0] step_period_ff, step_period_in;
   logic                   ramp_down_ff, ramp_down_in;
   logic                   dir_level_ff, dir_level_in;
   logic                   last_button_ff, last_button_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_BITS-1:0] pwm_period_ff, pwm_period_in;
   logic [PERIOD_BITS-2:0] pwm_pulse_ff, pwm_pulse_in;
   logic                   motor_dir_ff, motor_dir_in;

   logic                   req_xfer;
   logic [PERIOD_BITS:0]   long_sum;
   logic [PERIOD_BITS-1:0] short_diff;
   logic [PERIOD_BITS-1:0] next_period;
   logic                   at_max;
   logic                   at_min;
   logic                   pressed_twice;
   logic                   flip;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      min_period_in = min_period_ff;
      max_period_in = max_period_ff;
      accel_step_in = accel_step_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            spr_pkg::CSR_MIN_PERIOD: min_period_in = csr_wdata;
            spr_pkg::CSR_MAX_PERIOD: max_period_in = csr_wdata;
            spr_pkg::CSR_ACCEL_STEP: accel_step_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign long_sum   = {1'b0, step_period_ff} + {1'b0, accel_step_ff};
   assign short_diff = step_period_ff - accel_step_ff;

   always_comb begin
      if (ramp_down_ff) begin
         if (long_sum > {1'b0, max_period_ff}) begin
            next_period = max_period_ff;
         end else begin
            next_period = long_sum[PERIOD_BITS-1:0];
         end
      end else begin
         if ((step_period_ff < accel_step_ff) || (short_diff < min_period_ff)) begin
            next_period = min_period_ff;
         end else begin
            next_period = short_diff;
         end
      end
   end

   assign at_max        = (next_period == max_period_ff);
   assign at_min        = (next_period == min_period_ff);
   assign pressed_twice = !req_chan.button_level && !last_button_ff;
   assign flip          = (at_max || at_min) && pressed_twice;

   always_comb begin
      step_period_in = step_period_ff;
      ramp_down_in   = ramp_down_ff;
      dir_level_in   = dir_level_ff;
      last_button_in = last_button_ff;
      if (req_xfer) begin
         step_period_in = next_period;
         ramp_down_in   = ramp_down_ff ^ flip;
         dir_level_in   = dir_level_ff ^ (flip && at_max);
         last_button_in = req_chan.button_level;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      pwm_period_in = pwm_period_ff;
      pwm_pulse_in  = pwm_pulse_ff;
      motor_dir_in  = motor_dir_ff;
      if (req_xfer) begin
         rsp_valid_in  = 1'b1;
         pwm_period_in = step_period_ff;
         if (step_period_ff == max_period_ff) begin
            pwm_pulse_in = '0;
         end else begin
            pwm_pulse_in = step_period_ff[PERIOD_BITS-1:1];
         end
         motor_dir_in = dir_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff  <= PERIOD_BITS'(spr_pkg::RESET_MIN_PERIOD);
         max_period_ff  <= PERIOD_BITS'(spr_pkg::RESET_MAX_PERIOD);
         accel_step_ff  <= PERIOD_BITS'(spr_pkg::RESET_ACCEL_STEP);
         step_period_ff <= PERIOD_BITS'(spr_pkg::RESET_MAX_PERIOD);
         ramp_down_ff   <= 1'b0;
         dir_level_ff   <= 1'b0;
         last_button_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         min_period_ff  <= min_period_in;
         max_period_ff  <= max_period_in;
         accel_step_ff  <= accel_step_in;
         step_period_ff <= step_period_in;
         ramp_down_ff   <= ramp_down_in;
         dir_level_ff   <= dir_level_in;
         last_button_ff <= last_button_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pwm_period_ff <= pwm_period_in;
      pwm_pulse_ff  <= pwm_pulse_in;
      motor_dir_ff  <= motor_dir_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.pwm_period      = pwm_period_ff;
   assign rsp_chan.pwm_pulse       = pwm_pulse_ff;
   assign rsp_chan.motor_direction = motor_dir_ff;

`ifndef SYNTH
   a_xfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("accepted tick did not produce a result");

   a_state_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> ($stable(step_period_ff) && $stable(ramp_down_ff)
                     && $stable(dir_level_ff)))
      else $error("ramp state changed without a transfer");

   a_dir_only_with_flip: assert property (@(posedge clock) disable iff (reset)
      (dir_level_in != dir_level_ff) |-> (ramp_down_in != ramp_down_ff))
      else $error("motor direction toggled without a ramp reversal");

   a_pulse_within_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, pwm_pulse_ff} <= pwm_period_ff))
      else $error("pulse exceeds period");
`endif

endmodule

// ----- sim/stepper_period_ramp_tb.sv -----
// Self-checking testbench for the stepper period ramp block with random handshakes.
`timescale 1ns / 1ps

module stepper_period_ramp_tb;

   localparam int PW = spr_pkg::SPR_PERIOD_BITS;
   localparam logic [PW-1:0] PERIOD_ALL_ONES = {PW{1'b1}};
   localparam logic [spr_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_TICKS = 800;
   localparam int PRESSURE_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [PW-1:0] pwm_period;
      logic [PW-2:0] pwm_pulse;
      logic          motor_direction;
   } pwm_setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en;
   logic [spr_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [PW-1:0] csr_wdata;

   spr_req_if req_bus ();
   spr_rsp_if #(.PERIOD_BITS(PW)) rsp_bus ();

   stepper_period_ramp #(.PERIOD_BITS(PW)) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Predicted register and ramp state.
   logic [PW-1:0] min_limit = spr_pkg::RESET_MIN_PERIOD[PW-1:0];
   logic [PW-1:0] max_limit = spr_pkg::RESET_MAX_PERIOD[PW-1:0];
   logic [PW-1:0] accel_amount = spr_pkg::RESET_ACCEL_STEP[PW-1:0];
   logic [PW-1:0] cur_period = spr_pkg::RESET_MAX_PERIOD[PW-1:0];
   logic          ramping_down = 1'b0;
   logic          dir_pin = 1'b0;
   logic          prev_button = 1'b0;

   logic            pending_buttons[$];
   pwm_setting_type expected_pwm[$];
   pwm_setting_type got_pwm;

   int items_queued = 0;
   int results_checked = 0;
   int failures = 0;
   int ramp_reversals = 0;
   int dir_toggles = 0;
   int settings_used = 1;
   int send_gap_max = 0;
   int recv_gap_max = 0;
   int send_wait = 0;
   int recv_wait = 0;
   int hold_left = 0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int idle_cycles = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void advance_ramp(input logic button);
      pwm_setting_type want;
      logic [PW:0] sum;
      want.pwm_period = cur_period;
      want.pwm_pulse = (cur_period == max_limit) ? '0 : cur_period[PW-1:1];
      if (ramping_down) begin
         sum = {1'b0, cur_period} + {1'b0, accel_amount};
         cur_period = (sum > {1'b0, max_limit}) ? max_limit : sum[PW-1:0];
      end else if (cur_period < accel_amount || cur_period - accel_amount < min_limit) begin
         cur_period = min_limit;
      end else begin
         cur_period = cur_period - accel_amount;
      end
      if ((cur_period == max_limit || cur_period == min_limit) && !button && !prev_button) begin
         if (cur_period == max_limit) begin
            dir_pin = ~dir_pin;
            dir_toggles++;
         end
         ramping_down = ~ramping_down;
         ramp_reversals++;
      end
      prev_button = button;
      want.motor_direction = dir_pin;
      expected_pwm.push_back(want);
   endfunction

   function automatic void check_result(input pwm_setting_type want);
      if (got_pwm.pwm_period !== want.pwm_period) begin
         $error("pwm_period: expected %0d, got %0d", want.pwm_period, got_pwm.pwm_period);
         failures++;
      end
      if (got_pwm.pwm_pulse !== want.pwm_pulse) begin
         $error("pwm_pulse: expected %0d, got %0d", want.pwm_pulse, got_pwm.pwm_pulse);
         failures++;
      end
      if (got_pwm.motor_direction !== want.motor_direction) begin
         $error("motor_direction: expected %0d, got %0d", want.motor_direction,
                got_pwm.motor_direction);
         failures++;
      end
   endfunction

   task automatic write_reg(input logic [spr_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [PW-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         spr_pkg::CSR_MIN_PERIOD: min_limit = val;
         spr_pkg::CSR_MAX_PERIOD: max_limit = val;
         spr_pkg::CSR_ACCEL_STEP: accel_amount = val;
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input logic [PW-1:0] lo, input logic [PW-1:0] hi,
                             input logic [PW-1:0] st);
      write_reg(spr_pkg::CSR_MIN_PERIOD, lo);
      write_reg(spr_pkg::CSR_MAX_PERIOD, hi);
      write_reg(spr_pkg::CSR_ACCEL_STEP, st);
      settings_used++;
   endtask

   task automatic push_button(input logic level);
      pending_buttons.push_back(level);
      items_queued++;
   endtask

   // Runs of held and released button levels, so presses often span more than one tick.
   task automatic queue_button_runs(input int count);
      int left;
      int run;
      logic level;
      left = count;
      while (left > 0) begin
         level = 1'($urandom_range(0, 1));
         run = $urandom_range(1, 6);
         repeat (run) begin
            if (left > 0) begin
               push_button(level);
               left--;
            end
         end
      end
   endtask

   task automatic wait_idle();
      while (results_checked != items_queued) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Driver: presents queued button levels, with a random gap after each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.button_level <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            advance_ramp(req_bus.button_level);
            send_wait = $urandom_range(0, send_gap_max);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_wait == 0 && pending_buttons.size() > 0) begin
               req_bus.valid <= 1'b1;
               req_bus.button_level <= pending_buttons.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
               if (send_wait > 0) send_wait--;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            got_pwm.pwm_period = rsp_bus.pwm_period;
            got_pwm.pwm_pulse = rsp_bus.pwm_pulse;
            got_pwm.motor_direction = rsp_bus.motor_direction;
            if (expected_pwm.size() == 0) begin
               $error("unexpected result: pwm_period %0d", got_pwm.pwm_period);
               failures++;
            end else begin
               check_result(expected_pwm.pop_front());
            end
            recv_wait = $urandom_range(0, recv_gap_max);
            if (hold_armed && !hold_done) begin
               hold_left = PRESSURE_CYCLES;
               hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", idle_cycles);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [PW-1:0] lo;
      logic [PW-1:0] hi;
      logic [PW-1:0] st;
      int kind;
      int phase;
      req_bus.valid = 1'b0;
      req_bus.button_level = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, then saturation at both limits, reversals,
      // inverted limits, a zero step, an unused index and the widest values.
      send_gap_max = 2;
      recv_gap_max = 2;
      push_button(1'b0);
      push_button(1'b0);
      push_button(1'b1);
      wait_idle();
      set_limits(20, 50, PERIOD_ALL_ONES);
      push_button(1'b1);
      push_button(1'b0);
      push_button(1'b0);
      wait_idle();
      write_reg(spr_pkg::CSR_ACCEL_STEP, 15);
      push_button(1'b1);
      push_button(1'b1);
      push_button(1'b0);
      push_button(1'b0);
      push_button(1'b1);
      wait_idle();
      write_reg(CSR_UNUSED, PERIOD_ALL_ONES);
      write_reg(spr_pkg::CSR_MIN_PERIOD, 60);
      write_reg(spr_pkg::CSR_ACCEL_STEP, 0);
      push_button(1'b0);
      push_button(1'b0);
      push_button(1'b1);
      wait_idle();
      set_limits(0, PERIOD_ALL_ONES, PERIOD_ALL_ONES);
      push_button(1'b0);
      push_button(1'b0);
      push_button(1'b0);
      push_button(1'b1);
      push_button(1'b0);
      push_button(1'b0);
      wait_idle();

      phase = 0;
      while (items_queued < RANDOM_TICKS + 20) begin
         kind = $urandom_range(0, 6);
         case (kind)
            0, 1: begin
               lo = PW'($urandom_range(0, 1000));
               hi = lo + PW'($urandom_range(1, 500));
               st = PW'($urandom_range(1, 100));
               set_limits(lo, hi, st);
            end
            2: set_limits(PW'($urandom_range(0, PERIOD_ALL_ONES)),
                          PW'($urandom_range(0, PERIOD_ALL_ONES)),
                          PW'($urandom_range(0, PERIOD_ALL_ONES)));
            3: set_limits(PW'($urandom_range(0, 1)), PERIOD_ALL_ONES,
                          PW'($urandom_range(PERIOD_ALL_ONES / 2, PERIOD_ALL_ONES)));
            4: begin
               hi = PW'($urandom_range(0, 5000));
               set_limits(hi + PW'($urandom_range(1, 5000)), hi,
                          PW'($urandom_range(1, 3000)));
            end
            5: begin
               lo = PW'($urandom_range(0, PERIOD_ALL_ONES));
               set_limits(lo, ($urandom_range(0, 1) == 0) ? lo : PERIOD_ALL_ONES - lo, 0);
            end
            default: ;
         endcase
         if ($urandom_range(0, 7) == 0)
            write_reg(CSR_UNUSED, PW'($urandom_range(0, PERIOD_ALL_ONES)));
         send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
         recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
         if (phase == 3) begin
            send_gap_max = 0;
            hold_armed = 1'b1;
         end
         queue_button_runs($urandom_range(20, 80));
         wait_idle();
         phase++;
      end

      repeat (5) @(posedge clock);
      $display("covered %0d ticks over %0d register settings", results_checked, settings_used);
      $display("saw %0d ramp reversals and %0d direction toggles", ramp_reversals, dir_toggles);
      if (failures == 0 && expected_pwm.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
